FILE: sv/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
`timescale 1ns / 1ps
`default_nettype none
package hcbp_pkg;

    localparam int BYTE_BITS = 8;
    localparam int CODE_W    = 16;
    localparam int LEN_W     = 5;
    localparam int CNT_W     = 4;
    localparam int PAD_W     = 3;
    localparam int WORD_W    = BYTE_BITS + CODE_W;
    localparam int SHAMT_W   = 5;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FLUSH  = 2'd2
    } action_t;

    typedef struct packed {
        logic              is_flush;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        q_entry_t          head;
    } q_stat_t;

endpackage
`default_nettype wire

FILE: sv/hcbp_in_if.sv
// Input channel: table loads, encode requests and flushes.
`timescale 1ns / 1ps
`default_nettype none
interface hcbp_in_if;
    import hcbp_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       action;
    logic [7:0]       symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0] code_length;

    modport source (output valid, action, symbol, code_bits, code_length, input ready);
    modport sink   (input valid, action, symbol, code_bits, code_length, output ready);
endinterface
`default_nettype wire

FILE: sv/hcbp_out_if.sv
// Output channel: packed bytes.
`timescale 1ns / 1ps
`default_nettype none
interface hcbp_out_if;
    import hcbp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] out_byte;
    logic                 is_final;
    logic [PAD_W-1:0]     pad_count;
    logic                 last;

    modport source (output valid, out_byte, is_final, pad_count, last, input ready);
    modport sink   (input valid, out_byte, is_final, pad_count, last, output ready);
endinterface
`default_nettype wire

FILE: sv/hcbp_front.sv
// Front end: code table, item classification and table lookup.
`timescale 1ns / 1ps
`default_nettype none
module hcbp_front #(
    parameter int MAX_CODE_LEN  = 16,
    parameter int ALPHABET_SIZE = 256
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    hcbp_in_if.sink              item,
    input  wire hcbp_pkg::q_stat_t q_stat,
    output hcbp_pkg::q_push_t    push
);
    import hcbp_pkg::*;

    localparam int IDX_W     = $clog2(ALPHABET_SIZE);
    localparam int LEN_LIMIT = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;

    logic [CODE_W-1:0] code_mem [ALPHABET_SIZE];
    logic [LEN_W-1:0]  len_mem  [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] vld_reg;

    logic [CODE_W-1:0] rd_code_reg;
    logic [LEN_W-1:0]  rd_len_reg;
    logic              rd_vld_reg;
    logic              s1_valid_reg;
    logic              s1_flush_reg;

    logic             take;
    logic             sym_ok;
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] len_sat;
    logic             do_load;
    logic             do_encode;
    logic             do_flush;
    logic [CNT_W-1:0] occupancy;

    assign occupancy  = {1'b0, q_stat.count} + {{(CNT_W-1){1'b0}}, s1_valid_reg};
    assign item.ready = occupancy < CNT_W'(QDEPTH);
    assign take       = item.valid && item.ready;
    assign sym_ok     = {1'b0, item.symbol} < 9'(ALPHABET_SIZE);
    assign idx        = item.symbol[IDX_W-1:0];
    assign len_sat    = (item.code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                              : item.code_length;

    always_comb
    begin
        do_load   = 1'b0;
        do_encode = 1'b0;
        do_flush  = 1'b0;
        case (item.action)
            ACT_LOAD:   do_load   = take && sym_ok;
            ACT_ENCODE: do_encode = take && sym_ok;
            ACT_FLUSH:  do_flush  = take;
            default:    ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            code_mem[idx] <= item.code_bits;
            len_mem[idx]  <= len_sat;
        end
        if (do_encode)
        begin
            rd_code_reg <= code_mem[idx];
            rd_len_reg  <= len_mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_flush_reg <= 1'b0;
        end
        else
        begin
            if (do_load)
                vld_reg[idx] <= 1'b1;
            if (do_encode)
                rd_vld_reg <= vld_reg[idx];
            s1_valid_reg <= do_encode || do_flush;
            s1_flush_reg <= do_flush;
        end
    end

    assign push.valid          = s1_valid_reg;
    assign push.entry.is_flush = s1_flush_reg;
    assign push.entry.code     = rd_code_reg;
    assign push.entry.len      = (rd_vld_reg && !s1_flush_reg) ? rd_len_reg : '0;

endmodule
`default_nettype wire

FILE: sv/hcbp_queue.sv
// Short FIFO between the lookup front end and the packer.
`timescale 1ns / 1ps
`default_nettype none
module hcbp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hcbp_pkg::q_push_t push,
    input  wire logic              pop,
    output hcbp_pkg::q_stat_t      q_stat
);
    import hcbp_pkg::*;

    q_entry_t          mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem[wr_ptr_reg] <= push.entry;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (!push.valid && pop)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    assign q_stat.count = count_reg;
    assign q_stat.head  = mem[rd_ptr_reg];

endmodule
`default_nettype wire

FILE: sv/hcbp_back.sv
// Back end: bit buffer, byte packing and output register.
`timescale 1ns / 1ps
`default_nettype none
module hcbp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hcbp_pkg::q_stat_t q_stat,
    output logic                   pop,
    hcbp_out_if.source             result
);
    import hcbp_pkg::*;

    logic [BYTE_BITS-1:0] buf_reg;
    logic [BYTE_BITS-1:0] buf_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 pend_reg;
    logic                 pend_next;
    logic [BYTE_BITS-1:0] pend_byte_reg;
    logic [BYTE_BITS-1:0] pend_byte_next;

    logic                 o_valid_reg;
    logic                 o_valid_next;
    logic [BYTE_BITS-1:0] o_byte_reg;
    logic [BYTE_BITS-1:0] o_byte_next;
    logic                 o_final_reg;
    logic                 o_final_next;
    logic [PAD_W-1:0]     o_pad_reg;
    logic [PAD_W-1:0]     o_pad_next;
    logic                 o_last_reg;
    logic                 o_last_next;

    logic                 out_free;
    q_entry_t             head;
    logic [CODE_W-1:0]    code_m;
    logic [LEN_W-1:0]     total;
    logic [SHAMT_W-1:0]   shamt;
    logic [WORD_W-1:0]    word;

    assign head     = q_stat.head;
    assign out_free = !o_valid_reg || result.ready;
    assign pop      = out_free && !pend_reg && (q_stat.count != '0);

    assign code_m = head.code & ~({CODE_W{1'b1}} << head.len);
    assign total  = {1'b0, cnt_reg} + head.len;
    assign shamt  = SHAMT_W'(WORD_W) - total;
    assign word   = {buf_reg, {CODE_W{1'b0}}} | ({{BYTE_BITS{1'b0}}, code_m} << shamt);

    always_comb
    begin
        buf_next       = buf_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pend_byte_next = pend_byte_reg;
        o_valid_next   = o_valid_reg && !result.ready;
        o_byte_next    = o_byte_reg;
        o_final_next   = o_final_reg;
        o_pad_next     = o_pad_reg;
        o_last_next    = o_last_reg;

        if (out_free && pend_reg)
        begin
            o_valid_next = 1'b1;
            o_byte_next  = pend_byte_reg;
            o_final_next = 1'b0;
            o_pad_next   = '0;
            o_last_next  = 1'b1;
            pend_next    = 1'b0;
        end
        else if (pop)
        begin
            if (head.is_flush)
            begin
                if (cnt_reg != '0)
                begin
                    o_valid_next = 1'b1;
                    o_byte_next  = buf_reg;
                    o_final_next = 1'b1;
                    o_pad_next   = PAD_W'(CNT_W'(BYTE_BITS) - cnt_reg);
                    o_last_next  = 1'b1;
                end
                buf_next = '0;
                cnt_next = '0;
            end
            else if (total > LEN_W'(2 * BYTE_BITS))
            begin
                o_valid_next   = 1'b1;
                o_byte_next    = word[WORD_W-1 -: BYTE_BITS];
                o_final_next   = 1'b0;
                o_pad_next     = '0;
                o_last_next    = 1'b0;
                pend_next      = 1'b1;
                pend_byte_next = word[WORD_W-BYTE_BITS-1 -: BYTE_BITS];
                buf_next       = word[BYTE_BITS-1:0];
                cnt_next       = CNT_W'(total - LEN_W'(2 * BYTE_BITS));
            end
            else if (total > LEN_W'(BYTE_BITS))
            begin
                o_valid_next = 1'b1;
                o_byte_next  = word[WORD_W-1 -: BYTE_BITS];
                o_final_next = 1'b0;
                o_pad_next   = '0;
                o_last_next  = 1'b1;
                buf_next     = word[WORD_W-BYTE_BITS-1 -: BYTE_BITS];
                cnt_next     = CNT_W'(total - LEN_W'(BYTE_BITS));
            end
            else
            begin
                buf_next = word[WORD_W-1 -: BYTE_BITS];
                cnt_next = CNT_W'(total);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        o_byte_reg    <= o_byte_next;
        o_final_reg   <= o_final_next;
        o_pad_reg     <= o_pad_next;
        o_last_reg    <= o_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg     <= '0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            o_valid_reg <= o_valid_next;
        end
    end

    assign result.valid     = o_valid_reg;
    assign result.out_byte  = o_byte_reg;
    assign result.is_final  = o_final_reg;
    assign result.pad_count = o_pad_reg;
    assign result.last      = o_last_reg;

endmodule
`default_nettype wire

FILE: sv/huffman_code_bit_packer.sv
// The first output byte follows the input transfer through the front-end lookup registers,
// the queue and the output register. One item per cycle while the queue has room and
// the output is taken; an encode yielding two bytes holds the packer while its second byte waits in a pending register.
// Loads and unused actions produce nothing.
// Reset clears the code-length valid bits, bit buffer, queue and output; no
// clearing pass, the block is ready right after reset.
`timescale 1ns / 1ps
`default_nettype none
module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN  = 16,
    parameter int ALPHABET_SIZE = 256
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hcbp_in_if.sink    item,
    hcbp_out_if.source result
);
    import hcbp_pkg::*;

    q_push_t push;
    q_stat_t q_stat;
    logic    pop;

    hcbp_front #(
        .MAX_CODE_LEN  (MAX_CODE_LEN),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .q_stat (q_stat),
        .push   (push)
    );

    hcbp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .q_stat (q_stat)
    );

    hcbp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .pop    (pop),
        .result (result)
    );

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the Huffman code bit packer: directed table, then random stream.
`timescale 1ns / 1ps
module tb;
    import hcbp_pkg::*;

    localparam int MAX_LEN     = 16;
    localparam int ALPHA       = 256;
    localparam int LEN_LIMIT   = (MAX_LEN > CODE_W) ? CODE_W : MAX_LEN;
    localparam int N_RANDOM    = 1250;
    localparam int QUIET_FROM  = 500;
    localparam int QUIET_TO    = 750;
    localparam int IDLE_PCT    = 35;
    localparam int DRAIN       = 16;
    localparam int LIMIT       = 200000;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct {
        logic [1:0]        act;
        logic [7:0]        sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } item_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] data;
        logic                 fin;
        logic [PAD_W-1:0]     pad;
        logic                 last;
    } byte_res_t;

    typedef struct {
        item_t     it;
        bit        typed;
        int        nexp;
        byte_res_t e0;
        byte_res_t e1;
    } row_t;

    logic clk;
    logic rst_n;
    logic quiet;

    hcbp_in_if  item ();
    hcbp_out_if result ();

    huffman_code_bit_packer #(
        .MAX_CODE_LEN  (MAX_LEN),
        .ALPHABET_SIZE (ALPHA)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // predictor state
    logic [CODE_W-1:0]    code_tab [ALPHA];
    logic [LEN_W-1:0]     len_tab  [ALPHA];
    logic [BYTE_BITS-1:0] acc_buf;
    logic [CNT_W-1:0]     acc_cnt;
    bit                   sym_written [ALPHA];
    logic [7:0]           loaded_syms [$];

    byte_res_t exp_bytes [$];
    row_t      dir_rows [$];

    int errors;
    int n_items;
    int n_checked;
    int n_finals;
    int n_double;
    int cycles;

    function automatic byte_res_t mk_res(input logic [7:0] data, input logic fin,
                                         input logic [2:0] pad, input logic last);
        byte_res_t r;
        r.data = data;
        r.fin  = fin;
        r.pad  = pad;
        r.last = last;
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] act, input logic [7:0] sym,
                                    input logic [15:0] code, input logic [4:0] len,
                                    input bit typed, input int nexp,
                                    input byte_res_t e0, input byte_res_t e1);
        row_t r;
        r.it.act  = act;
        r.it.sym  = sym;
        r.it.code = code;
        r.it.len  = len;
        r.typed   = typed;
        r.nexp    = nexp;
        r.e0      = e0;
        r.e1      = e1;
        dir_rows.push_back(r);
    endfunction

    // Bit packing step: updates table and buffer, returns number of bytes produced.
    function automatic int pack_step(input item_t it, output byte_res_t r0,
                                     output byte_res_t r1);
        int n;
        int i;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        byte_res_t         b;
        n  = 0;
        r0 = '0;
        r1 = '0;
        case (it.act)
            ACT_LOAD:
            begin
                if (int'(it.sym) < ALPHA)
                begin
                    len = it.len;
                    if (len > LEN_W'(LEN_LIMIT))
                        len = LEN_W'(LEN_LIMIT);
                    code_tab[it.sym] = it.code;
                    len_tab[it.sym]  = len;
                    if (!sym_written[it.sym])
                    begin
                        sym_written[it.sym] = 1'b1;
                        loaded_syms.push_back(it.sym);
                    end
                end
            end
            ACT_ENCODE:
            begin
                if (int'(it.sym) < ALPHA)
                begin
                    len  = len_tab[it.sym];
                    code = code_tab[it.sym];
                    for (i = int'(len); i > 0; i--)
                    begin
                        if (acc_cnt >= CNT_W'(BYTE_BITS))
                        begin
                            b = mk_res(acc_buf, 1'b0, '0, 1'b0);
                            if (n == 0)
                                r0 = b;
                            else
                                r1 = b;
                            n++;
                            acc_buf = '0;
                            acc_cnt = '0;
                        end
                        acc_buf[BYTE_BITS - 1 - int'(acc_cnt)] = code[i-1];
                        acc_cnt++;
                    end
                    if (n == 1)
                        r0.last = 1'b1;
                    else if (n == 2)
                        r1.last = 1'b1;
                end
            end
            ACT_FLUSH:
            begin
                if (acc_cnt != '0)
                begin
                    r0 = mk_res(acc_buf, 1'b1, PAD_W'(BYTE_BITS - int'(acc_cnt)), 1'b1);
                    n  = 1;
                    acc_buf = '0;
                    acc_cnt = '0;
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    task automatic drive_item(input item_t it);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid       <= 1'b1;
        item.action      <= it.act;
        item.symbol      <= it.sym;
        item.code_bits   <= it.code;
        item.code_length <= it.len;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
    endtask

    // Called at the transfer edge: predicts and queues what the item must produce.
    task automatic accept(input item_t it, input bit typed, input int nexp,
                          input byte_res_t e0, input byte_res_t e1);
        int n;
        byte_res_t r0;
        byte_res_t r1;
        n = pack_step(it, r0, r1);
        n_items++;
        if (n == 2)
            n_double++;
        if (typed)
        begin
            if (nexp > 0)
                exp_bytes.push_back(e0);
            if (nexp > 1)
                exp_bytes.push_back(e1);
        end
        else
        begin
            if (n > 0)
                exp_bytes.push_back(r0);
            if (n > 1)
                exp_bytes.push_back(r1);
        end
    endtask

    function automatic item_t rand_item();
        item_t it;
        int    sel;
        sel = $urandom_range(0, 99);
        it.sym  = 8'($urandom_range(0, 255));
        it.code = CODE_W'($urandom);
        it.len  = LEN_W'($urandom_range(0, 31));
        if (sel < 18 || loaded_syms.size() == 0)
        begin
            it.act = ACT_LOAD;
            if ($urandom_range(0, 1) == 0)
                it.sym = 8'($urandom_range(0, 15));
            sel = $urandom_range(0, 9);
            if (sel < 7)
                it.len = LEN_W'($urandom_range(1, LEN_LIMIT));
            else if (sel == 7)
                it.len = '0;
        end
        else if (sel < 83)
        begin
            it.act = ACT_ENCODE;
            it.sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        end
        else if (sel < 96)
            it.act = ACT_FLUSH;
        else
            it.act = ACT_NONE;
        return it;
    endfunction

    // output ready
    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        byte_res_t e;
        if (rst_n && result.valid && result.ready)
        begin
            if (exp_bytes.size() == 0)
            begin
                $error("unexpected result: out_byte %h is_final %b pad_count %0d last %b",
                       result.out_byte, result.is_final, result.pad_count, result.last);
                errors++;
            end
            else
            begin
                e = exp_bytes.pop_front();
                n_checked++;
                if (result.is_final)
                    n_finals++;
                if (result.out_byte !== e.data)
                begin
                    $error("out_byte: expected %h, got %h", e.data, result.out_byte);
                    errors++;
                end
                if (result.is_final !== e.fin)
                begin
                    $error("is_final: expected %b, got %b", e.fin, result.is_final);
                    errors++;
                end
                if (result.pad_count !== e.pad)
                begin
                    $error("pad_count: expected %0d, got %0d", e.pad, result.pad_count);
                    errors++;
                end
                if (result.last !== e.last)
                begin
                    $error("last: expected %b, got %b", e.last, result.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: timeout after %0d cycles, %0d results outstanding",
                 cycles, exp_bytes.size());
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        item_t     it;
        byte_res_t z;
        int        k;
        errors    = 0;
        n_items   = 0;
        n_checked = 0;
        n_finals  = 0;
        n_double  = 0;
        acc_buf   = '0;
        acc_cnt   = '0;
        for (k = 0; k < ALPHA; k++)
        begin
            code_tab[k]    = '0;
            len_tab[k]     = '0;
            sym_written[k] = 1'b0;
        end
        z = '0;

        rst_n            <= 1'b0;
        quiet            <= 1'b0;
        item.valid       <= 1'b0;
        item.action      <= ACT_LOAD;
        item.symbol      <= '0;
        item.code_bits   <= '0;
        item.code_length <= '0;

        add_row(ACT_FLUSH,  8'd0,   16'h0000, 5'd0,  1, 0, z, z);   // empty flush
        add_row(ACT_LOAD,   8'd0,   16'hFFFF, 5'd0,  1, 0, z, z);
        add_row(ACT_ENCODE, 8'd0,   16'h0000, 5'd0,  1, 0, z, z);   // zero-length code
        add_row(ACT_NONE,   8'hFF,  16'hFFFF, 5'd31, 1, 0, z, z);   // unused action
        add_row(ACT_LOAD,   8'd255, 16'hFFFF, 5'd16, 1, 0, z, z);
        add_row(ACT_LOAD,   8'd1,   16'h0000, 5'd31, 1, 0, z, z);   // saturates to limit
        add_row(ACT_LOAD,   8'd2,   16'h55AA, 5'd8,  1, 0, z, z);
        add_row(ACT_LOAD,   8'd3,   16'h0001, 5'd1,  1, 0, z, z);
        add_row(ACT_LOAD,   8'd4,   16'h00FF, 5'd8,  1, 0, z, z);
        add_row(ACT_LOAD,   8'd6,   16'hFFF0, 5'd4,  1, 0, z, z);   // high code bits ignored
        add_row(ACT_ENCODE, 8'd255, 16'h0000, 5'd0,  1, 1, mk_res(8'hFF, 0, 0, 1), z);
        add_row(ACT_FLUSH,  8'd0,   16'h0000, 5'd0,  1, 1, mk_res(8'hFF, 1, 0, 1), z);
        add_row(ACT_ENCODE, 8'd1,   16'h0000, 5'd0,  1, 1, mk_res(8'h00, 0, 0, 1), z);
        add_row(ACT_ENCODE, 8'd2,   16'h0000, 5'd0,  0, 0, z, z);
        add_row(ACT_ENCODE, 8'd3,   16'h0000, 5'd0,  0, 0, z, z);
        add_row(ACT_FLUSH,  8'd0,   16'h0000, 5'd0,  1, 1, mk_res(8'h80, 1, 7, 1), z);
        add_row(ACT_ENCODE, 8'd4,   16'h0000, 5'd0,  1, 0, z, z);
        add_row(ACT_ENCODE, 8'd255, 16'h0000, 5'd0,  1, 2,
                mk_res(8'hFF, 0, 0, 0), mk_res(8'hFF, 0, 0, 1));
        add_row(ACT_FLUSH,  8'd0,   16'h0000, 5'd0,  1, 1, mk_res(8'hFF, 1, 0, 1), z);
        add_row(ACT_ENCODE, 8'd6,   16'h0000, 5'd0,  1, 0, z, z);
        add_row(ACT_FLUSH,  8'd0,   16'h0000, 5'd0,  1, 1, mk_res(8'h00, 1, 4, 1), z);
        add_row(ACT_ENCODE, 8'd3,   16'h0000, 5'd0,  0, 0, z, z);
        add_row(ACT_ENCODE, 8'd2,   16'h0000, 5'd0,  0, 0, z, z);
        add_row(ACT_FLUSH,  8'd0,   16'h0000, 5'd0,  0, 0, z, z);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            drive_item(dir_rows[i].it);
            accept(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].nexp,
                   dir_rows[i].e0, dir_rows[i].e1);
        end

        k = 0;
        while (k < N_RANDOM)
        begin
            quiet <= (k >= QUIET_FROM && k < QUIET_TO);
            it = rand_item();
            drive_item(it);
            accept(it, 1'b0, 0, z, z);
            if (it.act != ACT_NONE)
                k++;
        end
        item.valid <= 1'b0;
        quiet      <= 1'b0;

        while (exp_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("tb: %0d items transferred (%0d directed), %0d bytes checked",
                 n_items, dir_rows.size(), n_checked);
        $display("tb: %0d flush bytes, %0d two-byte encodes, %0d symbols loaded",
                 n_finals, n_double, loaded_syms.size());
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
